/* hdl/mhpq_pkg.sv */
`default_nettype none

package mhpq_pkg;

   localparam int VALUE_W  = 32;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int IDX_W    = 4;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [MODE_W-1:0]         mode_type;
   typedef logic [STATUS_W-1:0]       status_type;
   typedef logic [IDX_W-1:0]          idx_type;

   localparam mode_type MODE_INSERT = 2'd0;
   localparam mode_type MODE_DELETE = 2'd1;
   localparam mode_type MODE_READ   = 2'd2;

   localparam status_type STATUS_DONE      = 2'd0;
   localparam status_type STATUS_FULL      = 2'd1;
   localparam status_type STATUS_NOT_FOUND = 2'd2;
   localparam status_type STATUS_BAD_INDEX = 2'd3;

endpackage

`default_nettype wire

/* hdl/mhpq_if.sv */
`default_nettype none

interface mhpq_req_if
   import mhpq_pkg::*;
();
   logic      valid;
   logic      ready;
   mode_type  mode;
   value_type operand_value;
   idx_type   entry_index;

   modport source (output valid, mode, operand_value, entry_index, input ready);
   modport sink   (input valid, mode, operand_value, entry_index, output ready);
endinterface

interface mhpq_rsp_if
   import mhpq_pkg::*;
#(
   parameter int CNT_W = 5
) ();
   logic             valid;
   logic             ready;
   status_type       status;
   value_type        result_value;
   value_type        top_value;
   logic [CNT_W-1:0] count;

   modport source (output valid, status, result_value, top_value, count, input ready);
   modport sink   (input valid, status, result_value, top_value, count, output ready);
endinterface

`default_nettype wire

/* hdl/max_heap_priority_queue_core.sv */
// Binary max-heap priority queue of signed 32-bit values.
//
// req_ch carries one operation per transfer: insert operand_value, delete
// the first entry equal to operand_value, or read the entry at entry_index.
// rsp_ch returns one result per operation with a status, the read value,
// the current maximum and the entry count after the operation.
//
// The heap lives in a RAM with registered read; a small sequencer runs the
// search, swap and full bottom-up sift-down rebuild one access per cycle.
// A rejected insert, a read beyond count or the unused code only reads
// the root for the response; a read first fetches its entry; a delete
// searches entries in order, and an accepted insert or delete rebuilds
// the whole heap node by node with swaps, so it runs longer as the heap
// fills. req_ch.ready is high only while the sequencer is idle, so the
// next transfer comes at earliest the cycle after the result is registered.
//
// Reset empties the heap (count zero); memory contents are not cleared.
// The result sits in an output register: a new operation can be taken
// while it waits, but that operation holds its own result until rsp_ch
// has taken the previous one.

`default_nettype none

module max_heap_priority_queue_core
   import mhpq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   mhpq_req_if.sink   req_ch,
   mhpq_rsp_if.source rsp_ch
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int XW   = AW + 2;
   localparam int CMPW = (IDX_W > CW) ? IDX_W : CW;

   localparam logic [4:0] ST_IDLE      = 5'd0;
   localparam logic [4:0] ST_OP        = 5'd1;
   localparam logic [4:0] ST_SRCH_RD   = 5'd2;
   localparam logic [4:0] ST_SRCH_CMP  = 5'd3;
   localparam logic [4:0] ST_DEL_WR    = 5'd4;
   localparam logic [4:0] ST_READ_WAIT = 5'd5;
   localparam logic [4:0] ST_RB_START  = 5'd6;
   localparam logic [4:0] ST_SFT_RD    = 5'd7;
   localparam logic [4:0] ST_SFT_NODE  = 5'd8;
   localparam logic [4:0] ST_SFT_L     = 5'd9;
   localparam logic [4:0] ST_SFT_LCMP  = 5'd10;
   localparam logic [4:0] ST_SFT_RCMP  = 5'd11;
   localparam logic [4:0] ST_SFT_SWAP  = 5'd12;
   localparam logic [4:0] ST_SFT_SWAP2 = 5'd13;
   localparam logic [4:0] ST_TOP_RD    = 5'd14;
   localparam logic [4:0] ST_TOP_WAIT  = 5'd15;

   logic [4:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   mode_type      mode_ff, mode_in;
   value_type     val_ff, val_in;
   idx_type       idx_ff, idx_in;
   logic [CW-1:0] k_ff, k_in;
   logic [AW-1:0] node_ff, node_in;
   logic [AW-1:0] best_ff, best_in;
   value_type     nv_ff, nv_in;
   value_type     bv_ff, bv_in;
   status_type    status_ff, status_in;
   value_type     result_ff, result_in;

   status_type    rsp_status_ff, rsp_status_in;
   value_type     rsp_result_ff, rsp_result_in;
   value_type     rsp_top_ff, rsp_top_in;
   logic [CW-1:0] rsp_count_ff, rsp_count_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   value_type     ram_wdata;
   logic [AW-1:0] ram_raddr;
   value_type     ram_rdata;

   logic [XW-1:0] left_idx;
   logic [XW-1:0] right_idx;
   logic [XW-1:0] cnt_x;
   logic          rsp_free;

   mhpq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign left_idx  = XW'({node_ff, 1'b1});
   assign right_idx = left_idx + XW'(1);
   assign cnt_x     = XW'(cnt_ff);
   assign rsp_free  = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.result_value = rsp_result_ff;
   assign rsp_ch.top_value    = rsp_top_ff;
   assign rsp_ch.count        = rsp_count_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      mode_in       = mode_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      node_in       = node_ff;
      best_in       = best_ff;
      nv_in         = nv_ff;
      bv_in         = bv_ff;
      status_in     = status_ff;
      result_in     = result_ff;
      rsp_status_in = rsp_status_ff;
      rsp_result_in = rsp_result_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_count_in  = rsp_count_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = val_ff;
      ram_raddr     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               mode_in  = req_ch.mode;
               val_in   = req_ch.operand_value;
               idx_in   = req_ch.entry_index;
               state_in = ST_OP;
            end
         end
         ST_OP: begin
            status_in = STATUS_DONE;
            result_in = '0;
            k_in      = '0;
            case (mode_ff)
               MODE_INSERT: begin
                  if (cnt_ff >= CW'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_TOP_RD;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = AW'(cnt_ff);
                     cnt_in    = cnt_ff + CW'(1);
                     state_in  = ST_RB_START;
                  end
               end
               MODE_DELETE: begin
                  state_in = ST_SRCH_RD;
               end
               MODE_READ: begin
                  if (CMPW'(idx_ff) >= CMPW'(cnt_ff)) begin
                     status_in = STATUS_BAD_INDEX;
                     state_in  = ST_TOP_RD;
                  end else begin
                     ram_raddr = AW'(idx_ff);
                     state_in  = ST_READ_WAIT;
                  end
               end
               default: begin
                  state_in = ST_TOP_RD;
               end
            endcase
         end
         ST_SRCH_RD: begin
            if (k_ff >= cnt_ff) begin
               status_in = STATUS_NOT_FOUND;
               state_in  = ST_TOP_RD;
            end else begin
               ram_raddr = AW'(k_ff);
               state_in  = ST_SRCH_CMP;
            end
         end
         ST_SRCH_CMP: begin
            if (ram_rdata == val_ff) begin
               ram_raddr = AW'(cnt_ff - CW'(1));
               state_in  = ST_DEL_WR;
            end else begin
               k_in     = k_ff + CW'(1);
               state_in = ST_SRCH_RD;
            end
         end
         ST_DEL_WR: begin
            // last entry moves into the hole; the tail slot is dropped
            ram_we    = 1'b1;
            ram_waddr = AW'(k_ff);
            ram_wdata = ram_rdata;
            cnt_in    = cnt_ff - CW'(1);
            state_in  = ST_RB_START;
         end
         ST_READ_WAIT: begin
            result_in = ram_rdata;
            state_in  = ST_TOP_RD;
         end
         ST_RB_START: begin
            k_in     = cnt_ff >> 1;
            state_in = ST_SFT_RD;
         end
         ST_SFT_RD: begin
            if (k_ff == '0) begin
               state_in = ST_TOP_RD;
            end else begin
               node_in   = AW'(k_ff - CW'(1));
               ram_raddr = AW'(k_ff - CW'(1));
               state_in  = ST_SFT_NODE;
            end
         end
         ST_SFT_NODE: begin
            nv_in    = ram_rdata;
            state_in = ST_SFT_L;
         end
         ST_SFT_L: begin
            if (left_idx >= cnt_x) begin
               k_in     = k_ff - CW'(1);
               state_in = ST_SFT_RD;
            end else begin
               ram_raddr = AW'(left_idx);
               state_in  = ST_SFT_LCMP;
            end
         end
         ST_SFT_LCMP: begin
            if (ram_rdata > nv_ff) begin
               best_in = AW'(left_idx);
               bv_in   = ram_rdata;
            end else begin
               best_in = node_ff;
               bv_in   = nv_ff;
            end
            if (right_idx < cnt_x) begin
               ram_raddr = AW'(right_idx);
               state_in  = ST_SFT_RCMP;
            end else begin
               state_in = ST_SFT_SWAP;
            end
         end
         ST_SFT_RCMP: begin
            if (ram_rdata > bv_ff) begin
               best_in = AW'(right_idx);
               bv_in   = ram_rdata;
            end
            state_in = ST_SFT_SWAP;
         end
         ST_SFT_SWAP: begin
            if (best_ff == node_ff) begin
               k_in     = k_ff - CW'(1);
               state_in = ST_SFT_RD;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = node_ff;
               ram_wdata = bv_ff;
               state_in  = ST_SFT_SWAP2;
            end
         end
         ST_SFT_SWAP2: begin
            ram_we    = 1'b1;
            ram_waddr = best_ff;
            ram_wdata = nv_ff;
            node_in   = best_ff;
            state_in  = ST_SFT_L;
         end
         ST_TOP_RD: begin
            state_in = ST_TOP_WAIT;
         end
         ST_TOP_WAIT: begin
            // read address stays at the root so the data holds while stalled
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_result_in = result_ff;
               rsp_top_in    = (cnt_ff == '0) ? '0 : ram_rdata;
               rsp_count_in  = cnt_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      k_ff          <= k_in;
      node_ff       <= node_in;
      best_ff       <= best_in;
      nv_ff         <= nv_in;
      bv_ff         <= bv_in;
      status_ff     <= status_in;
      result_ff     <= result_in;
      rsp_status_ff <= rsp_status_in;
      rsp_result_ff <= rsp_result_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule

`default_nettype wire

/* hdl/mhpq_ram.sv */
`default_nettype none

module mhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* bench/max_heap_priority_queue_core_test.sv */
`default_nettype none

module max_heap_priority_queue_core_test;
   import mhpq_pkg::*;

   localparam int HEAP_DEPTH   = 16;
   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 80;
   localparam int PRINT_CAP    = 40;

   localparam mode_type MODE_UNUSED = 2'd3;

   typedef struct {
      status_type status;
      value_type  result_value;
      value_type  top_value;
      logic [4:0] count;
   } heap_reply_type;

   logic clock;
   logic reset;

   mhpq_req_if req_ch ();
   mhpq_rsp_if rsp_ch ();

   max_heap_priority_queue_core #(
      .CAPACITY(HEAP_DEPTH)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   value_type      shadow_heap [HEAP_DEPTH];
   int             shadow_count = 0;
   heap_reply_type replies_due [$];

   bit source_idle_on = 1'b1;
   bit sink_stall_on  = 1'b1;

   int error_count  = 0;
   int results_seen = 0;
   int quiet_cycles = 0;
   int peak_count   = 0;
   int op_tally [4] = '{0, 0, 0, 0};
   int status_tally [4] = '{0, 0, 0, 0};

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(string msg);
      error_count++;
      if (error_count <= PRINT_CAP) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endtask

   function automatic int pick_gap(bit enabled);
      int roll;
      if (!enabled) return 0;
      roll = $urandom_range(0, 19);
      if (roll == 0) return $urandom_range(10, 40);
      if (roll < 8) return $urandom_range(1, 3);
      return 0;
   endfunction

   function automatic value_type pick_value();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
         case ($urandom_range(0, 3))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return -32'sd1;
            default: return 32'sd0;
         endcase
      end
      if (roll < 4) return value_type'($urandom);
      return value_type'(int'($urandom_range(0, 40)) - 20);
   endfunction

   // strict greater-than, left child first
   function automatic void sift_heap(int node, int n);
      int best, lc, rc;
      value_type t;
      bit settled;
      settled = 1'b0;
      while (!settled) begin
         best = node;
         lc = 2 * node + 1;
         rc = lc + 1;
         if (lc < n && shadow_heap[lc] > shadow_heap[best]) best = lc;
         if (rc < n && shadow_heap[rc] > shadow_heap[best]) best = rc;
         if (best == node) begin
            settled = 1'b1;
         end else begin
            t = shadow_heap[node];
            shadow_heap[node] = shadow_heap[best];
            shadow_heap[best] = t;
            node = best;
         end
      end
   endfunction

   function automatic void rebuild_heap();
      for (int k = shadow_count / 2; k > 0; k--) sift_heap(k - 1, shadow_count);
   endfunction

   function automatic heap_reply_type run_heap_op(mode_type m, value_type v, idx_type ix);
      heap_reply_type r;
      int k;
      value_type t;
      r.status = STATUS_DONE;
      r.result_value = '0;
      case (m)
         MODE_INSERT: begin
            if (shadow_count >= HEAP_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               shadow_heap[shadow_count] = v;
               shadow_count++;
               rebuild_heap();
            end
         end
         MODE_DELETE: begin
            k = 0;
            while (k < shadow_count && shadow_heap[k] != v) k++;
            if (k >= shadow_count) begin
               r.status = STATUS_NOT_FOUND;
            end else begin
               t = shadow_heap[k];
               shadow_heap[k] = shadow_heap[shadow_count - 1];
               shadow_heap[shadow_count - 1] = t;
               shadow_count--;
               rebuild_heap();
            end
         end
         MODE_READ: begin
            if (int'(ix) >= shadow_count) r.status = STATUS_BAD_INDEX;
            else r.result_value = shadow_heap[ix];
         end
         default: begin
         end
      endcase
      r.top_value = (shadow_count > 0) ? shadow_heap[0] : '0;
      r.count = shadow_count[4:0];
      return r;
   endfunction

   task automatic send_op(mode_type m, value_type v, idx_type ix);
      heap_reply_type r;
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.mode <= m;
      req_ch.operand_value <= v;
      req_ch.entry_index <= ix;
      do @(posedge clock); while (!req_ch.ready);
      r = run_heap_op(m, v, ix);
      replies_due.push_back(r);
      op_tally[int'(m)]++;
      status_tally[int'(r.status)]++;
      if (shadow_count > peak_count) peak_count = shadow_count;
      gap = pick_gap(source_idle_on);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic test_empty_heap();
      send_op(MODE_READ, '0, 4'd15);
      send_op(MODE_DELETE, 32'sd0, '0);
      send_op(MODE_UNUSED, 32'sh5a5a_a5a5, 4'd9);
   endtask

   task automatic test_extreme_values();
      send_op(MODE_INSERT, 32'sh8000_0000, '0);
      send_op(MODE_INSERT, 32'sh7fff_ffff, '0);
      send_op(MODE_INSERT, 32'sd0, '0);
      send_op(MODE_INSERT, -32'sd1, '0);
      send_op(MODE_INSERT, 32'sd7, '0);
      send_op(MODE_INSERT, 32'sd7, '0);
      send_op(MODE_READ, '0, 4'd0);
      send_op(MODE_READ, '0, 4'd6);
      send_op(MODE_DELETE, 32'sh8000_0000, '0);
      send_op(MODE_DELETE, 32'sd12345, '0);
      send_op(MODE_DELETE, 32'sd7, '0);
      send_op(MODE_READ, '0, 4'd3);
   endtask

   task automatic test_full_heap();
      int k;
      for (k = shadow_count; k < HEAP_DEPTH; k++) begin
         send_op(MODE_INSERT, value_type'(k * 37 - 200), '0);
      end
      send_op(MODE_INSERT, 32'sd1, '0);
      send_op(MODE_READ, '0, 4'd15);
      send_op(MODE_DELETE, shadow_heap[HEAP_DEPTH - 1], '0);
   endtask

   // growing/shrinking phases so the heap swings between empty and full
   task automatic test_random_traffic(int target);
      int done_items, seg_left, roll;
      bit growing;
      mode_type m;
      value_type v;
      idx_type ix;
      done_items = 0;
      seg_left = 0;
      growing = 1'b1;
      while (done_items < target) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(40, 200);
            source_idle_on = ($urandom_range(0, 3) != 0);
            sink_stall_on = ($urandom_range(0, 3) != 0);
         end
         seg_left--;
         if (shadow_count == HEAP_DEPTH) growing = 1'b0;
         else if (shadow_count == 0) growing = 1'b1;
         else if ($urandom_range(0, 63) == 0) growing = ~growing;
         roll = $urandom_range(0, 99);
         v = pick_value();
         ix = idx_type'($urandom_range(0, 15));
         if (roll < 3) begin
            m = MODE_UNUSED;
         end else if (roll < 25) begin
            m = MODE_READ;
            if (shadow_count > 0 && $urandom_range(0, 3) != 0) begin
               ix = idx_type'($urandom_range(0, shadow_count - 1));
            end
         end else if (roll < (growing ? 75 : 40)) begin
            m = MODE_INSERT;
         end else begin
            m = MODE_DELETE;
            if (shadow_count > 0 && $urandom_range(0, 3) != 0) begin
               v = shadow_heap[$urandom_range(0, shadow_count - 1)];
            end
         end
         send_op(m, v, ix);
         if (m != MODE_UNUSED) done_items++;
      end
   endtask

   initial begin : result_check
      heap_reply_type want;
      int gap_left;
      gap_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (replies_due.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with none pending", results_seen));
            end else begin
               want = replies_due.pop_front();
               if (rsp_ch.status !== want.status)
                  report_mismatch($sformatf("result %0d status got %0d want %0d",
                     results_seen, rsp_ch.status, want.status));
               if (rsp_ch.result_value !== want.result_value)
                  report_mismatch($sformatf("result %0d result_value got %0d want %0d",
                     results_seen, rsp_ch.result_value, want.result_value));
               if (rsp_ch.top_value !== want.top_value)
                  report_mismatch($sformatf("result %0d top_value got %0d want %0d",
                     results_seen, rsp_ch.top_value, want.top_value));
               if (rsp_ch.count !== want.count)
                  report_mismatch($sformatf("result %0d count got %0d want %0d",
                     results_seen, rsp_ch.count, want.count));
            end
            gap_left = pick_gap(sink_stall_on);
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (sink_stall_on && $urandom_range(0, 11) == 0) begin
            gap_left = $urandom_range(1, 6);
         end
         rsp_ch.ready <= (gap_left == 0);
      end
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("no transfer for %0d cycles, %0d results outstanding",
         QUIET_LIMIT, replies_due.size());
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.mode <= MODE_INSERT;
      req_ch.operand_value <= '0;
      req_ch.entry_index <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_heap();
      test_extreme_values();
      test_full_heap();
      test_random_traffic(1420);
      req_ch.valid <= 1'b0;

      while (replies_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ops: %0d insert, %0d delete, %0d read, %0d unused code; peak depth %0d",
         op_tally[0], op_tally[1], op_tally[2], op_tally[3], peak_count);
      $display("status: %0d done, %0d full, %0d not found, %0d bad index; %0d errors",
         status_tally[0], status_tally[1], status_tally[2], status_tally[3], error_count);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
